@@ rtl/servo_motion_step_defines.svh @@
// ----------------------------------------------------------------------------
// servo_motion_step_defines
// Assertion macros used by the servo step RTL.
// ----------------------------------------------------------------------------
`ifndef SERVO_MOTION_STEP_DEFINES_SVH
`define SERVO_MOTION_STEP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sms_pkg.sv @@
// ----------------------------------------------------------------------------
// sms_pkg
// Shared types and constants of the servo motion step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sms_pkg;

    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic signed [23:0] VEL_STOP = 24'sd26;

    typedef enum logic [2:0] {
        REG_CW_LIMIT  = 3'd0,
        REG_CCW_LIMIT = 3'd1,
        REG_MAX_VEL   = 3'd2,
        REG_MAX_ACC   = 3'd3,
        REG_FRICTION  = 3'd4,
        REG_TICK      = 3'd5
    } cfg_idx_t;

    // operand pairs of the shared multiplier
    typedef enum logic [1:0] {
        MOP_CFG    = 2'd0,
        MOP_DECAY  = 2'd1,
        MOP_TRAVEL = 2'd2
    } mop_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FDT,
        ST_LIM,
        ST_VMUL,
        ST_VEL,
        ST_PMUL,
        ST_PADD,
        ST_PFIX,
        ST_PRES,
        ST_EMIT
    } st_t;

    typedef struct packed {
        logic idle;
        logic mul_en;
        mop_t mul_op;
        logic ld_diff;
        logic ld_lim;
        logic ld_tgt;
        logic ld_vel;
        logic ld_sum;
        logic ld_pos;
        logic ld_pres;
        logic ld_out;
    } ctrl_t;

endpackage

`default_nettype wire

@@ rtl/servo_motion_step.sv @@
// ----------------------------------------------------------------------------
// servo_motion_step
// One simulation tick of a servo axis per input word, one result word out.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one tick word (goal position, goal speed, torque on).
//   m_* channel returns one word per tick (present position, present speed,
//   moving, angle error). cfg_wr_* writes the limit and rate registers; write
//   only while no tick is in flight.
//   The sequencer walks each tick through three products on the single
//   shared multiplier, with the rounding and clamp steps between them,
//   before it emits the result and returns to idle.
//   s_tready is high only while the sequencer is idle. The result sits in an
//   output register, so a new tick is taken while the last result waits; if
//   the receiver still stalls when the next result is done, the sequencer
//   holds in its last step until the output register frees.
//   Reset (aresetn low, synchronous) restores the register defaults,
//   position 2048.0, zero velocity, held goal 2048 and torque off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "servo_motion_step_defines.svh"

module servo_motion_step (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,     // goal, speed command, torque enable
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,     // position, speed, moving,
                                          // angle_error
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_wr_addr,
    input  wire logic [15:0] cfg_wr_data
);
    import sms_pkg::*;

    ctrl_t ctrl;
    logic  accept;
    logic  out_free;
    logic  wheel;

    // configuration
    logic [11:0] cw_reg, ccw_reg, maxv_reg;
    logic [15:0] macc_reg, fric_reg, dt_reg;

    // axis state
    logic signed [31:0] pos_reg, pos_next;
    logic signed [23:0] vel_reg, vel_next;
    logic [11:0]        held_goal_reg, held_goal_next;
    logic               twon_reg, twon_next;

    // per-tick working registers
    logic [10:0]        gspeed_reg, gspeed_next;
    logic               torque_reg, torque_next;
    logic               aerr_reg, aerr_next;
    logic signed [33:0] diff_reg, diff_next;
    logic [16:0]        factor_reg, factor_next;
    logic [24:0]        maxch_reg, maxch_next;
    logic signed [28:0] tgt16_reg, tgt16_next;
    logic signed [23:0] target_reg, target_next;
    logic signed [33:0] sum_reg, sum_next;
    logic [11:0]        ppos_reg, ppos_next;

    // output word
    logic               m_valid_reg, m_valid_next;
    logic [11:0]        out_pos_reg, out_pos_next;
    logic [10:0]        out_spd_reg, out_spd_next;
    logic               out_mov_reg, out_mov_next;
    logic               out_aerr_reg, out_aerr_next;

    // multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-9:0]  rnd8;
    logic signed [PROD_W-17:0] rnd16;

    // datapath temporaries
    logic [11:0]        in_goal;
    logic               goal_ok;
    logic signed [36:0] diff_x, d5, cap_x;
    logic [11:0]        vmax;
    logic signed [28:0] t_abs;
    logic [20:0]        t_rnd;
    logic signed [23:0] t_pos, wheel_tgt;
    logic signed [25:0] vel_x, verr, mc_x, v_up, v_dn;
    logic signed [23:0] vdrive, vcoast;
    logic signed [33:0] lo_x, hi_x;
    logic [32:0]        psum;
    logic [23:0]        vabs;
    logic [15:0]        vmag;
    logic signed [12:0] gdiff;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = ctrl.idle;
    assign wheel    = (cw_reg == 12'd0) && (ccw_reg == 12'd0);
    assign in_goal  = s_tdata[11:0];
    assign goal_ok  = (in_goal >= cw_reg) && (in_goal <= ccw_reg);

    sms_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    sms_mul u_mul (
        .aclk  (aclk),
        .en    (ctrl.mul_en),
        .a     (mul_a),
        .b     (mul_b),
        .rnd8  (rnd8),
        .rnd16 (rnd16)
    );

    always_comb begin
        case (ctrl.mul_op)
            MOP_CFG: begin
                mul_a = torque_reg ? $signed({9'd0, macc_reg}) : $signed({9'd0, fric_reg});
                mul_b = $signed({2'd0, dt_reg});
            end
            MOP_DECAY: begin
                mul_a = twon_reg ? '0 : $signed({vel_reg[23], vel_reg});
                mul_b = $signed({1'b0, factor_reg});
            end
            MOP_TRAVEL: begin
                mul_a = $signed({vel_reg[23], vel_reg});
                mul_b = $signed({2'd0, dt_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cw_reg   <= 12'd0;
            ccw_reg  <= 12'd4095;
            maxv_reg <= 12'd1023;
            macc_reg <= 16'd4096;
            fric_reg <= 16'd6554;
            dt_reg   <= 16'd655;
        end else if (cfg_wr_en) begin
            case (cfg_wr_addr)
                REG_CW_LIMIT:  cw_reg   <= cfg_wr_data[11:0];
                REG_CCW_LIMIT: ccw_reg  <= cfg_wr_data[11:0];
                REG_MAX_VEL:   maxv_reg <= cfg_wr_data[11:0];
                REG_MAX_ACC:   macc_reg <= cfg_wr_data;
                REG_FRICTION:  fric_reg <= cfg_wr_data;
                REG_TICK:      dt_reg   <= cfg_wr_data;
                default:       cw_reg   <= cw_reg;
            endcase
        end
    end

    // goal check at accept, targets and limits
    always_comb begin
        held_goal_next = held_goal_reg;
        aerr_next      = aerr_reg;
        gspeed_next    = gspeed_reg;
        torque_next    = torque_reg;
        if (accept) begin
            gspeed_next = s_tdata[22:12];
            torque_next = s_tdata[23];
            aerr_next   = !wheel && !goal_ok;
            if (!wheel && goal_ok) begin
                held_goal_next = in_goal;
            end
        end

        diff_next = diff_reg;
        if (ctrl.ld_diff) begin
            diff_next = $signed({6'd0, held_goal_reg, 16'd0})
                      - $signed({{2{pos_reg[31]}}, pos_reg});
        end

        diff_x = $signed({{3{diff_reg[33]}}, diff_reg});
        d5     = (diff_x <<< 2) + diff_x;
        vmax   = (gspeed_reg[9:0] == 10'd0) ? maxv_reg : {2'd0, gspeed_reg[9:0]};
        cap_x  = $signed({9'd0, vmax, 16'd0});

        factor_next = factor_reg;
        maxch_next  = maxch_reg;
        tgt16_next  = tgt16_reg;
        if (ctrl.ld_lim) begin
            factor_next = 17'(18'd65536 - {1'b0, rnd16[16:0]});
            maxch_next  = rnd8[24:0];
            if (d5 > cap_x) begin
                tgt16_next = cap_x[28:0];
            end else if (d5 < -cap_x) begin
                tgt16_next = 29'(-cap_x);
            end else begin
                tgt16_next = d5[28:0];
            end
        end

        t_abs     = tgt16_reg[28] ? -tgt16_reg : tgt16_reg;
        t_rnd     = 21'((29'(t_abs) + 29'd128) >> 8);
        t_pos     = tgt16_reg[28] ? -$signed({3'd0, t_rnd}) : $signed({3'd0, t_rnd});
        wheel_tgt = gspeed_reg[10] ? -$signed({6'd0, gspeed_reg[9:0], 8'd0})
                                   : $signed({6'd0, gspeed_reg[9:0], 8'd0});
        target_next = target_reg;
        if (ctrl.ld_tgt) begin
            target_next = wheel ? wheel_tgt : t_pos;
        end
    end

    // velocity and position updates
    always_comb begin
        vel_x = $signed({{2{vel_reg[23]}}, vel_reg});
        verr  = $signed({{2{target_reg[23]}}, target_reg}) - vel_x;
        mc_x  = $signed({1'b0, maxch_reg});
        v_up  = vel_x + mc_x;
        v_dn  = vel_x - mc_x;
        if (verr > mc_x) begin
            vdrive = v_up[23:0];
        end else if (verr < -mc_x) begin
            vdrive = v_dn[23:0];
        end else begin
            vdrive = target_reg;
        end
        vcoast = rnd16[23:0];
        if (vcoast > -VEL_STOP && vcoast < VEL_STOP) begin
            vcoast = '0;
        end

        lo_x = $signed({6'd0, cw_reg, 16'd0});
        hi_x = $signed({6'd0, ccw_reg, 16'd0});

        vel_next  = vel_reg;
        twon_next = twon_reg;
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        if (ctrl.ld_vel) begin
            vel_next  = torque_reg ? vdrive : vcoast;
            twon_next = torque_reg;
        end
        if (ctrl.ld_sum) begin
            sum_next = $signed({{2{pos_reg[31]}}, pos_reg}) + rnd8[33:0];
        end
        if (ctrl.ld_pos) begin
            if (!torque_reg) begin
                if (sum_reg > 34'sh0_7FFF_FFFF) begin
                    pos_next = 32'sh7FFF_FFFF;
                end else if (sum_reg < 34'sh3_8000_0000) begin
                    pos_next = 32'sh8000_0000;
                end else begin
                    pos_next = sum_reg[31:0];
                end
            end else if (wheel) begin
                pos_next = $signed({4'd0, sum_reg[27:0]});
            end else if (sum_reg < lo_x) begin
                pos_next = lo_x[31:0];
                vel_next = '0;
            end else if (sum_reg > hi_x) begin
                pos_next = hi_x[31:0];
                vel_next = '0;
            end else begin
                pos_next = sum_reg[31:0];
            end
        end
    end

    // result word
    always_comb begin
        psum      = {1'b0, pos_reg} + 33'h0_8000;
        ppos_next = ppos_reg;
        if (ctrl.ld_pres) begin
            if (pos_reg <= 32'sd0) begin
                ppos_next = 12'd0;
            end else if (psum[32:16] > 17'd4095) begin
                ppos_next = 12'd4095;
            end else begin
                ppos_next = psum[27:16];
            end
        end

        vabs  = vel_reg[23] ? 24'(-vel_reg) : 24'(vel_reg);
        vmag  = vabs[23:8];
        gdiff = $signed({1'b0, ppos_reg}) - $signed({1'b0, held_goal_reg});

        out_pos_next  = out_pos_reg;
        out_spd_next  = out_spd_reg;
        out_mov_next  = out_mov_reg;
        out_aerr_next = out_aerr_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        if (ctrl.ld_out) begin
            m_valid_next  = 1'b1;
            out_pos_next  = ppos_reg;
            out_spd_next  = {vel_reg[23], (vmag > 16'd1023) ? 10'h3FF : vmag[9:0]};
            out_mov_next  = torque_reg && ((vel_reg > 24'sd256) || (vel_reg < -24'sd256)
                          || (gdiff > 13'sd10) || (gdiff < -13'sd10));
            out_aerr_next = aerr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= 32'sh0800_0000;
            vel_reg       <= '0;
            held_goal_reg <= 12'd2048;
            twon_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            vel_reg       <= vel_next;
            held_goal_reg <= held_goal_next;
            twon_reg      <= twon_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        gspeed_reg   <= gspeed_next;
        torque_reg   <= torque_next;
        aerr_reg     <= aerr_next;
        diff_reg     <= diff_next;
        factor_reg   <= factor_next;
        maxch_reg    <= maxch_next;
        tgt16_reg    <= tgt16_next;
        target_reg   <= target_next;
        sum_reg      <= sum_next;
        ppos_reg     <= ppos_next;
        out_pos_reg  <= out_pos_next;
        out_spd_reg  <= out_spd_next;
        out_mov_reg  <= out_mov_next;
        out_aerr_reg <= out_aerr_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, out_aerr_reg, out_mov_reg, out_spd_reg, out_pos_reg};

    `SMS_ASSERT_NEXT(a_busy_after_take, accept, !s_tready, "input taken while busy")
    `SMS_ASSERT_NOW(a_valid_from_emit, $rose(m_valid_reg), $past(ctrl.ld_out),
                    "result raised outside emit step")
    `SMS_ASSERT_NOW(a_wheel_wrap, ctrl.ld_pres && torque_reg && wheel, pos_reg[31:28] == 4'd0,
                    "wheel position not wrapped")
    `SMS_ASSERT_NOW(a_coast_stop, ctrl.ld_pres && !torque_reg,
                    (vel_reg == 24'sd0) || (vel_reg >= VEL_STOP) || (vel_reg <= -VEL_STOP),
                    "coasting velocity below stop threshold")

endmodule

`default_nettype wire

@@ rtl/sms_mul.sv @@
// ----------------------------------------------------------------------------
// sms_mul
// Shared signed multiplier, registered product, half-away-from-zero rounding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sms_mul (
    input  wire logic                               aclk,
    input  wire logic                               en,
    input  wire logic signed [sms_pkg::MUL_A_W-1:0] a,
    input  wire logic signed [sms_pkg::MUL_B_W-1:0] b,
    output logic signed [sms_pkg::PROD_W-9:0]       rnd8,
    output logic signed [sms_pkg::PROD_W-17:0]      rnd16
);
    import sms_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic        [PROD_W-1:0] pabs;
    logic        [PROD_W-1:0] sum8;
    logic        [PROD_W-1:0] sum16;
    logic        [PROD_W-9:0] mag8;
    logic        [PROD_W-17:0] mag16;

    assign prod_next = PROD_W'(a) * PROD_W'(b);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    always_comb begin
        pabs  = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        sum8  = pabs + PROD_W'(128);
        sum16 = pabs + PROD_W'(32768);
        mag8  = sum8[PROD_W-1:8];
        mag16 = sum16[PROD_W-1:16];
        rnd8  = prod_reg[PROD_W-1] ? $signed(-mag8) : $signed(mag8);
        rnd16 = prod_reg[PROD_W-1] ? $signed(-mag16) : $signed(mag16);
    end

endmodule

`default_nettype wire

@@ rtl/sms_seq.sv @@
// ----------------------------------------------------------------------------
// sms_seq
// Step sequencer: walks one tick through the shared multiplier schedule.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sms_seq (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      start,
    input  wire logic      out_free,
    output sms_pkg::ctrl_t ctrl
);
    import sms_pkg::*;

    st_t state_reg;
    st_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_FDT;
                end
            end
            ST_FDT:  state_next = ST_LIM;
            ST_LIM:  state_next = ST_VMUL;
            ST_VMUL: state_next = ST_VEL;
            ST_VEL:  state_next = ST_PMUL;
            ST_PMUL: state_next = ST_PADD;
            ST_PADD: state_next = ST_PFIX;
            ST_PFIX: state_next = ST_PRES;
            ST_PRES: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        ctrl.mul_op = MOP_CFG;
        case (state_reg)
            ST_IDLE: ctrl.idle = 1'b1;
            ST_FDT: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_op  = MOP_CFG;
                ctrl.ld_diff = 1'b1;
            end
            ST_LIM:  ctrl.ld_lim = 1'b1;
            ST_VMUL: begin
                ctrl.mul_en = 1'b1;
                ctrl.mul_op = MOP_DECAY;
                ctrl.ld_tgt = 1'b1;
            end
            ST_VEL:  ctrl.ld_vel = 1'b1;
            ST_PMUL: begin
                ctrl.mul_en = 1'b1;
                ctrl.mul_op = MOP_TRAVEL;
            end
            ST_PADD: ctrl.ld_sum  = 1'b1;
            ST_PFIX: ctrl.ld_pos  = 1'b1;
            ST_PRES: ctrl.ld_pres = 1'b1;
            ST_EMIT: ctrl.ld_out  = out_free;
            default: ctrl.idle    = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the servo motion step. Tick words go in on the
// s_ stream and every accepted word is run through a bit-exact fixed-point
// model of the axis kept here. Each result word on the m_ stream is compared
// field by field with the oldest predicted status. Directed ticks cover
// position mode, limit rejection and clamping, inverted limits, wheel mode
// wrap and reverse, and coasting. Random phases follow with fresh register
// settings, held-goal runs, and random stalls on both streams.
// ----------------------------------------------------------------------------
module testbench;
    import sms_pkg::*;

    typedef struct packed {
        logic [11:0] position;
        logic [10:0] speed;
        logic        moving;
        logic        angle_err;
    } tick_result_t;

    localparam int     STALL_LIMIT   = 4000;
    localparam int     SETTLE_CYCLES = 12;
    localparam longint POS_MIN       = -64'sd2147483648;
    localparam longint POS_MAX       = 64'sd2147483647;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata     = '0;   // goal, speed command, torque enable
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;            // position, speed, moving,
                                     // angle_error
    logic        cfg_wr_en   = 1'b0;
    logic [2:0]  cfg_wr_addr = '0;
    logic [15:0] cfg_wr_data = '0;

    // axis state and register shadow
    int cw_lim   = 0;
    int ccw_lim  = 4095;
    int max_vel  = 1023;
    int max_acc  = 4096;
    int friction = 6554;
    int tick_per = 655;
    int pos_acc  = 2048 * 65536;
    int vel_acc  = 0;
    int goal_hold = 2048;
    bit torque_prev = 1'b0;

    tick_result_t expected_status[$];
    int err_count   = 0;
    int idle_cycles = 0;
    bit no_gaps     = 1'b0;

    servo_motion_step DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_addr (cfg_wr_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // shift right, rounding half away from zero
    function automatic longint rnd_shr(longint x, int n);
        longint half;
        half = 64'sd1 <<< (n - 1);
        if (x >= 0) return (x + half) >>> n;
        return -(((-x) + half) >>> n);
    endfunction

    function automatic longint clip(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic tick_result_t advance_servo(logic [11:0] goal, logic [10:0] gspeed,
                                                   logic torque);
        tick_result_t r;
        bit     wheel;
        longint p, v, dt, fd, factor, tgt, maxch, cap, d16, spd_cap, ppos, mag, diff;
        wheel       = (cw_lim == 0) && (ccw_lim == 0);
        r.angle_err = 1'b0;
        r.moving    = 1'b0;
        p  = longint'(pos_acc);
        v  = longint'(vel_acc);
        dt = longint'(tick_per);
        if (!wheel) begin
            if (int'(goal) >= cw_lim && int'(goal) <= ccw_lim) goal_hold = int'(goal);
            else r.angle_err = 1'b1;
        end
        if (!torque) begin
            fd     = (longint'(friction) * dt + 32768) >>> 16;
            factor = 65536 - fd;
            if (torque_prev) v = 0;
            v = rnd_shr(v * factor, 16);
            if (v > -26 && v < 26) v = 0;
            p = clip(p + rnd_shr(v * dt, 8), POS_MIN, POS_MAX);
        end else begin
            if (wheel) begin
                tgt = longint'(gspeed[9:0]) <<< 8;
                if (gspeed[10]) tgt = -tgt;
            end else begin
                spd_cap = (gspeed[9:0] == 0) ? longint'(max_vel) : longint'(gspeed[9:0]);
                cap = spd_cap <<< 16;
                d16 = (longint'(goal_hold) * 65536 - p) * 5;
                d16 = clip(d16, -cap, cap);
                tgt = rnd_shr(d16, 8);
            end
            maxch = (longint'(max_acc) * dt + 128) >>> 8;
            v = v + clip(tgt - v, -maxch, maxch);
            p = p + rnd_shr(v * dt, 8);
            if (!wheel) begin
                if (p < longint'(cw_lim) * 65536) begin
                    p = longint'(cw_lim) * 65536;
                    v = 0;
                end else if (p > longint'(ccw_lim) * 65536) begin
                    p = longint'(ccw_lim) * 65536;
                    v = 0;
                end
            end else begin
                p = p & 64'h0FFF_FFFF;
            end
        end
        pos_acc     = int'(p);
        vel_acc     = int'(v);
        torque_prev = torque;

        if (p <= 0) begin
            ppos = 0;
        end else begin
            ppos = (p + 32768) >>> 16;
            if (ppos > 4095) ppos = 4095;
        end
        mag = ((v < 0) ? -v : v) >>> 8;
        r.speed     = (mag > 1023) ? 11'd1023 : 11'(mag);
        r.speed[10] = (v < 0);
        r.position  = ppos[11:0];
        if (torque) begin
            diff = ppos - longint'(goal_hold);
            if (diff < 0) diff = -diff;
            r.moving = (v > 256) || (v < -256) || (diff > 10);
        end
        return r;
    endfunction

    task automatic flag_error(string msg);
        $display("%0t ERROR %s", $time, msg);
        err_count++;
    endtask

    task automatic write_reg(cfg_idx_t idx, int val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_addr <= idx;
        cfg_wr_data <= val[15:0];
        case (idx)
            REG_CW_LIMIT:  cw_lim   = val & 12'hFFF;
            REG_CCW_LIMIT: ccw_lim  = val & 12'hFFF;
            REG_MAX_VEL:   max_vel  = val & 12'hFFF;
            REG_MAX_ACC:   max_acc  = val & 16'hFFFF;
            REG_FRICTION:  friction = val & 16'hFFFF;
            REG_TICK:      tick_per = val & 16'hFFFF;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_servo_config(int cw, int ccw, int mv, int ma, int fr, int tp);
        write_reg(REG_CW_LIMIT, cw);
        write_reg(REG_CCW_LIMIT, ccw);
        write_reg(REG_MAX_VEL, mv);
        write_reg(REG_MAX_ACC, ma);
        write_reg(REG_FRICTION, fr);
        write_reg(REG_TICK, tp);
    endtask

    task automatic send_tick(logic [11:0] goal, logic [10:0] gspeed, logic torque);
        int gap;
        tick_result_t pending;
        @(negedge aclk);
        gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {torque, gspeed, goal};
        do @(posedge aclk); while (s_tready !== 1'b1);
        pending = advance_servo(goal, gspeed, torque);
        expected_status = {expected_status, pending};
    endtask

    // stop sending and wait until every result word is back
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic test_defaults();
        send_tick(12'd2048, 11'd0, 1'b1);
        send_tick(12'd4095, 11'd1023, 1'b1);
        send_tick(12'd4095, 11'd1023, 1'b1);
        send_tick(12'd0, 11'h7FF, 1'b1);      // reverse bit ignored here
        send_tick(12'd0, 11'd0, 1'b1);        // zero speed -> max velocity cap
        send_tick(12'd0, 11'd0, 1'b0);        // torque drop zeroes velocity
        send_tick(12'd100, 11'd0, 1'b0);
    endtask

    task automatic test_limits();
        drain_results();
        set_servo_config(1000, 3000, 1023, 65535, 6554, 65535);
        send_tick(12'd0, 11'd500, 1'b1);
        send_tick(12'd4095, 11'd500, 1'b1);
        send_tick(12'd999, 11'd500, 1'b1);
        send_tick(12'd3001, 11'd500, 1'b1);
        send_tick(12'd3000, 11'd1023, 1'b1);  // runs into the upper clamp
        send_tick(12'd3000, 11'd1023, 1'b1);
        send_tick(12'd1000, 11'd1023, 1'b1);
        drain_results();
        set_servo_config(3000, 1000, 1023, 65535, 6554, 65535);  // inverted limits
        send_tick(12'd2000, 11'd0, 1'b1);
        send_tick(12'd3000, 11'd0, 1'b1);
    endtask

    task automatic test_wheel();
        drain_results();
        set_servo_config(0, 0, 1023, 65535, 0, 65535);
        send_tick(12'd4095, 11'd1023, 1'b1);
        send_tick(12'd4095, 11'd1023, 1'b1);
        send_tick(12'd4095, 11'd1023, 1'b1);  // wraps past 4096
        send_tick(12'd0, 11'h7FF, 1'b1);
        send_tick(12'd0, 11'h7FF, 1'b1);
        send_tick(12'd0, 11'h400, 1'b1);      // reverse, zero magnitude
        send_tick(12'd123, 11'd0, 1'b0);
        drain_results();
        write_reg(REG_MAX_ACC, 1);
        write_reg(REG_TICK, 655);
        send_tick(12'd0, 11'h401, 1'b1);      // tiny negative velocity
        send_tick(12'd0, 11'h401, 1'b1);
    endtask

    task automatic test_random();
        int phase, sent, run_len, cw, ccw;
        logic [11:0] goal;
        logic [10:0] gspeed;
        logic torque;
        for (phase = 0; phase < 10; phase++) begin
            drain_results();
            no_gaps = (phase % 4 == 3);
            case (phase)
                0: set_servo_config(0, 4095, 4095, 65535, 65535, 65535);
                1: set_servo_config(4095, 4095, 1, 1, 0, 1);
                2: set_servo_config(0, 0, $urandom_range(1, 4095), $urandom_range(1, 65535),
                                    $urandom_range(0, 65535), $urandom_range(1, 65535));
                default: begin
                    if ($urandom_range(0, 3) == 0) begin
                        cw  = 0;
                        ccw = 0;
                    end else begin
                        cw  = $urandom_range(0, 4095);
                        ccw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, cw)
                                                          : $urandom_range(cw, 4095);
                    end
                    set_servo_config(cw, ccw, $urandom_range(1, 4095),
                                     $urandom_range(1, 65535), $urandom_range(0, 65535),
                                     $urandom_range(1, 65535));
                end
            endcase
            sent = 0;
            while (sent < 100) begin
                run_len = $urandom_range(1, 20);
                if (!(cw_lim == 0 && ccw_lim == 0) && cw_lim <= ccw_lim
                    && $urandom_range(0, 7) != 0)
                    goal = 12'($urandom_range(cw_lim, ccw_lim));
                else
                    goal = 12'($urandom_range(0, 4095));
                gspeed = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 1) << 10)
                                                     : 11'($urandom_range(0, 2047));
                torque = ($urandom_range(0, 7) != 0);
                repeat (run_len) begin
                    if ($urandom_range(0, 15) == 0) torque = !torque;
                    send_tick(goal, gspeed, torque);
                    sent++;
                    if ($urandom_range(0, 99) == 0) drain_results();
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    // result receiver with random stalls
    initial begin
        int k;
        forever begin
            k = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
            if (k > 0) begin
                m_tready <= 1'b0;
                repeat (k) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(aresetn && m_tvalid === 1'b1 && m_tready));
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin : check_results
        tick_result_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (expected_status.size() == 0) begin
                flag_error($sformatf("result word %h with nothing expected", m_tdata));
            end else begin
                want = expected_status.pop_front();
                if (m_tdata[11:0] !== want.position)
                    flag_error($sformatf("position %0d, expected %0d",
                                         m_tdata[11:0], want.position));
                if (m_tdata[22:12] !== want.speed)
                    flag_error($sformatf("speed %h, expected %h",
                                         m_tdata[22:12], want.speed));
                if (m_tdata[23] !== want.moving)
                    flag_error($sformatf("moving %b, expected %b", m_tdata[23], want.moving));
                if (m_tdata[24] !== want.angle_err)
                    flag_error($sformatf("angle_error %b, expected %b",
                                         m_tdata[24], want.angle_err));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        test_defaults();
        test_limits();
        test_wheel();
        test_random();
        drain_results();
        if (expected_status.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_status.size()));
        if (err_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule
